>>> hdl/cst_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the card set table.
package cst_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int REQ_W    = 3;
  localparam int CODE_W   = 6;
  localparam int RANK_W   = 4;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  localparam int NUM_CODES = 2 ** CODE_W;
  localparam int JOKER_CODE = 52;
  localparam int NUM_RANKS = 13;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RANK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PICKUP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FILL   = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // how the datapath closes out a request
  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_NOTFOUND,
    FIN_EMPTY,
    FIN_FULL,
    FIN_PRESENT,
    FIN_INSERT,
    FIN_HIT,
    FIN_DROP
  } fin_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic shift_wr;
    logic div_start;
    logic div_step;
    logic fill_start;
    logic fill_step;
    fin_e fin;
    logic out_push;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             present;
    logic             full;
    logic             empty;
    logic             hit;
    logic             exhausted;
    logic             rd_vld;
    logic             div_last;
    logic             fill_last;
    logic             out_free;
  } sts_t;

  // rank 1..13 of a suit card, 0 for the joker and codes above it
  function automatic logic [RANK_W-1:0] rank_of(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] r;
    r = code;
    if (code >= CODE_W'(JOKER_CODE)) begin
      r = '0;
    end else if (code >= CODE_W'(3 * NUM_RANKS)) begin
      r = code - CODE_W'(3 * NUM_RANKS) + CODE_W'(1);
    end else if (code >= CODE_W'(2 * NUM_RANKS)) begin
      r = code - CODE_W'(2 * NUM_RANKS) + CODE_W'(1);
    end else if (code >= CODE_W'(NUM_RANKS)) begin
      r = code - CODE_W'(NUM_RANKS) + CODE_W'(1);
    end else begin
      r = code + CODE_W'(1);
    end
    return RANK_W'(r);
  endfunction

endpackage

>>> hdl/card_set_table_top.sv
`timescale 1ns / 1ps
// Accept to result word: a new insert and the full, empty or absent-code cases go from decode
// straight to the result; the rest scan the slots, then shift to compact, one RAM read per cycle;
// pickup first runs the divider for pos % count. Fill deck walks the codes, one code per cycle.
// One request at a time; the next word is taken the cycle after the result is loaded
// into the output register. Reset (async, active low) empties the set at once;
// slot RAM contents are not cleared.
module card_set_table_top import cst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // card_code[5:0], rank[9:6], position[15:10]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [REQ_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // found_slot[5:0], card_out[11:6], count[18:12], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  logic [SLOT_W-1:0]  out_slot;
  logic [CODE_W-1:0]  out_card;
  logic [COUNT_W-1:0] out_count;

  cst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cst_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (s_axis_tuser),
    .in_code_i   (s_axis_tdata[5:0]),
    .in_rank_i   (s_axis_tdata[9:6]),
    .in_pos_i    (s_axis_tdata[15:10]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(m_axis_tuser),
    .out_slot_o  (out_slot),
    .out_card_o  (out_card),
    .out_count_o (out_count)
  );

  assign m_axis_tdata = {
    (OUT_TDATA_W - SLOT_W - CODE_W - COUNT_W)'(0), out_count, out_card, out_slot
  };

endmodule

>>> hdl/cst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cst_datapath.sv
`timescale 1ns / 1ps
// Datapath: slot RAM, count, code presence map, scan/shift pipe, divider, result.
module cst_datapath import cst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [REQ_W-1:0]    in_req_i,
  input  logic [CODE_W-1:0]   in_code_i,
  input  logic [RANK_W-1:0]   in_rank_i,
  input  logic [POS_W-1:0]    in_pos_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [SLOT_W-1:0]   out_slot_o,
  output logic [CODE_W-1:0]   out_card_o,
  output logic [COUNT_W-1:0]  out_count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int DBIT_W = $clog2(POS_W);

  // request word
  logic [REQ_W-1:0]    req_q;
  logic [CODE_W-1:0]   code_q;
  logic [RANK_W-1:0]   rank_q;
  logic [POS_W-1:0]    pos_q;

  // set state
  logic [CNT_W-1:0]     count_q;
  logic [NUM_CODES-1:0] present_q;

  // scan pipe
  logic [CNT_W-1:0]  idx_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;

  // divider and fill
  logic [CNT_W-1:0]  rem_q;
  logic [DBIT_W-1:0] dbit_q;
  logic [CODE_W-1:0] fill_q;

  // pending result
  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [CODE_W-1:0]   res_card_q;

  // output register
  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [CODE_W-1:0]   out_card_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic [CODE_W-1:0] rdata;
  logic              in_list;
  logic              match;
  logic              hit;
  logic              full;
  logic              fill_new;
  logic [RANK_W-1:0] rd_rank;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    dvs;
  logic [CNT_W-1:0]  rem_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic              ram_re;

  assign in_list  = idx_q < count_q;
  assign full     = count_q >= CNT_W'(CAPACITY);
  assign fill_new = !present_q[fill_q];
  assign rd_rank  = rank_of(rdata);

  always_comb begin
    if (req_q == REQ_PICKUP) begin
      match = 1'b1;
    end else if (req_q == REQ_RANK) begin
      match = (rd_rank == rank_q) && (rd_rank != '0);
    end else begin
      match = rdata == code_q;
    end
  end

  assign hit = rd_vld_q && match;

  // one restoring step of pos % count
  assign trial = {rem_q, pos_q[dbit_q]};
  assign dvs   = {1'b0, count_q};
  assign rem_nxt = (trial >= dvs) ? CNT_W'(trial - dvs) : CNT_W'(trial);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    ram_wdata = code_q;
    if (cmd_i.fin == FIN_INSERT) begin
      ram_we = 1'b1;
    end
    if (cmd_i.fill_step && fill_new && !full) begin
      ram_we    = 1'b1;
      ram_wdata = fill_q;
    end
    if (cmd_i.shift_wr && rd_vld_q) begin
      // entry behind the gap moves down by one
      ram_we    = 1'b1;
      ram_waddr = rd_idx_q - IDX_W'(1);
      ram_wdata = rdata;
    end
  end

  assign ram_re = cmd_i.scan_run && in_list;

  cst_ram #(
    .WIDTH(CODE_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_req_i;
      code_q <= in_code_i;
      rank_q <= in_rank_i;
      pos_q  <= in_pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      present_q <= '0;
    end else begin
      if (cmd_i.fin == FIN_INSERT) begin
        present_q[code_q] <= 1'b1;
        count_q           <= count_q + CNT_W'(1);
      end else if (cmd_i.fin == FIN_DROP) begin
        present_q[res_card_q] <= 1'b0;
        count_q               <= count_q - CNT_W'(1);
      end else if (cmd_i.fill_step && fill_new && !full) begin
        present_q[fill_q] <= 1'b1;
        count_q           <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.scan_start) begin
      idx_q    <= (req_q == REQ_PICKUP) ? rem_q : '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      rd_vld_q <= in_list;
      rd_idx_q <= idx_q[IDX_W-1:0];
      if (in_list) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      dbit_q <= DBIT_W'(POS_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_nxt;
      dbit_q <= dbit_q - DBIT_W'(1);
    end
    if (cmd_i.fill_start) begin
      fill_q <= '0;
    end else if (cmd_i.fill_step) begin
      fill_q <= fill_q + CODE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q <= ST_OK;
      res_slot_q   <= '0;
      res_card_q   <= '0;
    end else begin
      unique case (cmd_i.fin)
        FIN_NOTFOUND: res_status_q <= ST_NOTFOUND;
        FIN_EMPTY:    res_status_q <= ST_EMPTY;
        FIN_FULL:     res_status_q <= ST_FULL;
        FIN_PRESENT: begin
          res_status_q <= ST_PRESENT;
          res_slot_q   <= SLOT_W'(rd_idx_q);
        end
        FIN_INSERT:   res_slot_q <= SLOT_W'(count_q);
        FIN_HIT: begin
          res_slot_q <= SLOT_W'(rd_idx_q);
          res_card_q <= rdata;
        end
        default: ;
      endcase
      if (cmd_i.fill_step && fill_new && full) begin
        res_status_q <= ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_card_q   <= res_card_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign sts_o.req       = req_q;
  assign sts_o.present   = present_q[code_q];
  assign sts_o.full      = full;
  assign sts_o.empty     = count_q == '0;
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = !rd_vld_q && !in_list;
  assign sts_o.rd_vld    = rd_vld_q;
  assign sts_o.div_last  = dbit_q == '0;
  assign sts_o.fill_last = fill_q == CODE_W'(JOKER_CODE);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_card_o   = out_card_q;
  assign out_count_o  = out_count_q;

  // the set holds distinct codes, so the presence map tracks the count
  a_present_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(present_q) == int'(count_q))
    else $error("presence map out of step with entry count");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift_wr && rd_vld_q) |-> (rd_idx_q != '0) && (CNT_W'(rd_idx_q) < count_q))
    else $error("shift write outside the occupied slots");

endmodule

>>> hdl/cst_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences decode, divide, scan, shift, fill and result hand-off.
module cst_ctrl import cst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SSTART = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    cmd_o     = '0;
    cmd_o.fin = FIN_NONE;
    state_d   = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts_i.req)
          REQ_INSERT: begin
            priority if (sts_i.present) begin
              state_d = S_SSTART;
            end else if (sts_i.full) begin
              cmd_o.fin = FIN_FULL;
              state_d   = S_OUT;
            end else begin
              cmd_o.fin = FIN_INSERT;
              state_d   = S_OUT;
            end
          end
          REQ_REMOVE: begin
            if (sts_i.present) begin
              state_d = S_SSTART;
            end else begin
              cmd_o.fin = FIN_NOTFOUND;
              state_d   = S_OUT;
            end
          end
          REQ_RANK: state_d = S_SSTART;
          REQ_PICKUP: begin
            if (sts_i.empty) begin
              cmd_o.fin = FIN_EMPTY;
              state_d   = S_OUT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          REQ_FILL: begin
            cmd_o.fill_start = 1'b1;
            state_d          = S_FILL;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SSTART;
        end
      end
      S_SSTART: begin
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        // reads keep running so the shift can pick up behind a hit
        cmd_o.scan_run = 1'b1;
        priority if (sts_i.hit) begin
          if (sts_i.req == REQ_INSERT) begin
            cmd_o.fin = FIN_PRESENT;
            state_d   = S_OUT;
          end else begin
            cmd_o.fin = FIN_HIT;
            state_d   = S_SHIFT;
          end
        end else if (sts_i.exhausted) begin
          cmd_o.fin = FIN_NOTFOUND;
          state_d   = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SHIFT: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.shift_wr = 1'b1;
        if (!sts_i.rd_vld) begin
          cmd_o.fin = FIN_DROP;
          state_d   = S_OUT;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_push |-> sts_i.out_free)
    else $error("result pushed over a word not yet taken");

  a_load_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (in_valid_i && in_ready_o))
    else $error("request loaded without a handshake");

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fin != FIN_NONE) |-> !in_ready_o)
    else $error("request closed out while idle");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench of the card set table: directed plan, then random traffic with stalls.
module tb;
  import cst_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int PLAN_LEN = 25;
  localparam int RANDOM_WORDS = 1050;
  localparam int PHASE_LEN = 60;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CODE_W-1:0]   card;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CODE_W-1:0] code;
    logic [RANK_W-1:0] rank;
    logic [POS_W-1:0]  pos;
    logic              typed;
    outcome_t          want;
  } plan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  logic [CODE_W-1:0] held_codes[$];
  outcome_t          awaited[$];
  int                failures = 0;
  bit                no_idle = 1'b0;
  plan_row_t         plan[PLAN_LEN];

  card_set_table_top #(.CAPACITY(CAP)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic int find_code(input logic [CODE_W-1:0] code);
    for (int i = 0; i < held_codes.size(); i++) begin
      if (held_codes[i] == code) return i;
    end
    return -1;
  endfunction

  // joker and codes above it carry no rank
  function automatic int find_rank(input logic [RANK_W-1:0] rank);
    for (int i = 0; i < held_codes.size(); i++) begin
      if (held_codes[i] < CODE_W'(JOKER_CODE) &&
          (int'(held_codes[i]) % NUM_RANKS) + 1 == int'(rank)) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_to_set(input logic [REQ_W-1:0] req,
                                            input logic [CODE_W-1:0] code,
                                            input logic [RANK_W-1:0] rank,
                                            input logic [POS_W-1:0] pos);
    outcome_t res;
    int at;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_INSERT: begin
        at = find_code(code);
        if (at >= 0) begin
          res.status = ST_PRESENT;
          res.slot = SLOT_W'(at);
        end else if (held_codes.size() >= CAP) begin
          res.status = ST_FULL;
        end else begin
          res.slot = SLOT_W'(held_codes.size());
          held_codes.push_back(code);
        end
      end
      REQ_REMOVE, REQ_RANK: begin
        at = (req == REQ_REMOVE) ? find_code(code) : find_rank(rank);
        if (at < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.slot = SLOT_W'(at);
          res.card = held_codes[at];
          held_codes.delete(at);
        end
      end
      REQ_PICKUP: begin
        if (held_codes.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          at = int'(pos) % held_codes.size();
          res.slot = SLOT_W'(at);
          res.card = held_codes[at];
          held_codes.delete(at);
        end
      end
      REQ_FILL: begin
        for (int c = 0; c <= JOKER_CODE; c++) begin
          if (find_code(CODE_W'(c)) < 0) begin
            if (held_codes.size() >= CAP) res.status = ST_FULL;
            else held_codes.push_back(CODE_W'(c));
          end
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(held_codes.size());
    return res;
  endfunction

  // mostly short idles, a few long ones
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [CODE_W-1:0] code,
                              input logic [RANK_W-1:0] rank, input logic [POS_W-1:0] pos,
                              input logic typed, input outcome_t want);
    int gap;
    outcome_t res;
    gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, rank, code};
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = apply_to_set(req, code, rank, pos);
    awaited.push_back(typed ? want : res);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (!no_idle && $urandom_range(0, 99) < 30) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    outcome_t exp_w;
    outcome_t act_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_w.status = m_axis_tuser;
      act_w.slot   = m_axis_tdata[5:0];
      act_w.card   = m_axis_tdata[11:6];
      act_w.count  = m_axis_tdata[18:12];
      if (awaited.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d card %0d count %0d",
               act_w.status, act_w.slot, act_w.card, act_w.count);
        failures++;
      end else begin
        exp_w = awaited.pop_front();
        if (act_w.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, act_w.status);
          failures++;
        end
        if (act_w.slot !== exp_w.slot) begin
          $error("found_slot: expected %0d, got %0d", exp_w.slot, act_w.slot);
          failures++;
        end
        if (act_w.card !== exp_w.card) begin
          $error("card_out: expected %0d, got %0d", exp_w.card, act_w.card);
          failures++;
        end
        if (act_w.count !== exp_w.count) begin
          $error("count: expected %0d, got %0d", exp_w.count, act_w.count);
          failures++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [REQ_W-1:0]  req;
    logic [CODE_W-1:0] code;
    logic [RANK_W-1:0] rank;
    logic [POS_W-1:0]  pos;
    int phase;
    int roll;

    // rows 4..13 and 19..21 fall back on the predictor
    plan = '{
      '{REQ_PICKUP, 6'd0,  4'd0,  6'd0,  1'b1, '{ST_EMPTY,    6'd0,  6'd0, 7'd0}},
      '{REQ_REMOVE, 6'd5,  4'd0,  6'd0,  1'b1, '{ST_NOTFOUND, 6'd0,  6'd0, 7'd0}},
      '{REQ_RANK,   6'd0,  4'd1,  6'd0,  1'b1, '{ST_NOTFOUND, 6'd0,  6'd0, 7'd0}},
      '{REQ_INSERT, 6'd63, 4'd0,  6'd0,  1'b1, '{ST_OK,       6'd0,  6'd0, 7'd1}},
      '{REQ_INSERT, 6'd62, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd61, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd60, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd59, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd58, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd57, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd56, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd55, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd54, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd53, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_INSERT, 6'd63, 4'd0,  6'd0,  1'b1, '{ST_PRESENT,  6'd0,  6'd0, 7'd11}},
      '{REQ_FILL,   6'd0,  4'd0,  6'd0,  1'b1, '{ST_OK,       6'd0,  6'd0, 7'd64}},
      '{REQ_RANK,   6'd0,  4'd0,  6'd0,  1'b1, '{ST_NOTFOUND, 6'd0,  6'd0, 7'd64}},
      '{REQ_RANK,   6'd0,  4'd15, 6'd0,  1'b1, '{ST_NOTFOUND, 6'd0,  6'd0, 7'd64}},
      '{REQ_INSERT, 6'd0,  4'd0,  6'd0,  1'b1, '{ST_PRESENT,  6'd11, 6'd0, 7'd64}},
      '{REQ_RANK,   6'd0,  4'd13, 6'd0,  1'b0, '0},
      '{REQ_PICKUP, 6'd0,  4'd0,  6'd63, 1'b0, '0},
      '{REQ_REMOVE, 6'd52, 4'd0,  6'd0,  1'b0, '0},
      '{REQ_SPARE_LO, 6'd0, 4'd0, 6'd0,  1'b1, '{ST_OK,       6'd0,  6'd0, 7'd61}},
      '{REQ_SPARE_HI, 6'd63, 4'd15, 6'd63, 1'b1, '{ST_OK,     6'd0,  6'd0, 7'd61}},
      '{REQ_REMOVE, 6'd63, 4'd0,  6'd0,  1'b1, '{ST_NOTFOUND, 6'd0,  6'd0, 7'd61}}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      send_request(plan[i].req, plan[i].code, plan[i].rank, plan[i].pos,
                   plan[i].typed, plan[i].want);
    end

    // phases: grow, shrink, mixed without idles, mixed
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      phase = (n / PHASE_LEN) % 4;
      no_idle = (phase == 2);
      code = CODE_W'($urandom());
      rank = RANK_W'($urandom());
      pos  = POS_W'($urandom());
      roll = $urandom_range(0, 99);
      if (phase == 0) begin
        if (roll < 55)      req = REQ_INSERT;
        else if (roll < 60) req = REQ_FILL;
        else if (roll < 72) req = REQ_REMOVE;
        else if (roll < 82) req = REQ_RANK;
        else if (roll < 95) req = REQ_PICKUP;
        else                req = REQ_W'($urandom_range(5, 7));
      end else if (phase == 1) begin
        if (roll < 10)      req = REQ_INSERT;
        else if (roll < 12) req = REQ_FILL;
        else if (roll < 40) req = REQ_REMOVE;
        else if (roll < 65) req = REQ_RANK;
        else if (roll < 96) req = REQ_PICKUP;
        else                req = REQ_W'($urandom_range(5, 7));
      end else begin
        if (roll < 35)      req = REQ_INSERT;
        else if (roll < 38) req = REQ_FILL;
        else if (roll < 55) req = REQ_REMOVE;
        else if (roll < 70) req = REQ_RANK;
        else if (roll < 93) req = REQ_PICKUP;
        else                req = REQ_W'($urandom_range(5, 7));
      end
      if (req == REQ_INSERT && $urandom_range(0, 99) < 75) begin
        code = CODE_W'($urandom_range(0, JOKER_CODE));
      end
      // removes mostly hit a held code
      if (req == REQ_REMOVE && held_codes.size() > 0 && $urandom_range(0, 99) < 70) begin
        code = held_codes[$urandom_range(0, held_codes.size() - 1)];
      end
      if (req == REQ_RANK && $urandom_range(0, 99) < 85) begin
        rank = RANK_W'($urandom_range(1, NUM_RANKS));
      end
      send_request(req, code, rank, pos, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cst_pkg.sv
hdl/cst_ram.sv
hdl/cst_datapath.sv
hdl/cst_ctrl.sv
hdl/card_set_table_top.sv
bench/tb.sv
